FILE: sv/bfa_pkg.sv
// Shared types and constants of the bitmap frame allocator.
`default_nettype none

package bfa_pkg;

	localparam int unsigned FRAME_W      = 12;
	localparam int unsigned CNT_W        = 13;
	localparam int unsigned FRAMES_TOTAL = 4096;
	localparam logic [CNT_W-1:0] MAX_FRAMES = CNT_W'(FRAMES_TOTAL);

	// request kinds; the fourth code is refused
	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_RESERVE = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_DONE   = 2'd0;
	localparam logic [1:0] STAT_NO_RUN = 2'd1;
	localparam logic [1:0] STAT_BAD    = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [FRAME_W-1:0] start_frame;
		logic [CNT_W-1:0]   frame_count;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FRAME_W-1:0] frame;
		logic [CNT_W-1:0]   free_count;
	} res_t;

	// outcome of searching one map word for a free run
	typedef struct packed {
		logic               found;
		logic [FRAME_W-1:0] first;
		logic [CNT_W-1:0]   run_next;
	} eval_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DIV,
		ST_BASE,
		ST_MARK
	} state_t;

endpackage

`default_nettype wire

FILE: sv/bitmap_frame_allocator.sv
// Bitmap page frame allocator top level: request sequencer around the used map.
//
// One request is taken when start is high and busy is low; busy stays high
// until the result goes out, and done pulses for exactly one cycle with the
// result, which the receiver must take then. The used map lives in one RAM of
// MAP_WORD_BITS-bit words with one read and one write port; a per-word valid
// flag makes unwritten words read as all used, so no clearing pass follows
// reset. An allocate scans map words one per cycle from frame 0 up to the
// first fitting run, then marks the run word by word, reading the next word
// while writing the previous one. Release and reserve go straight to marking
// the words that their range touches; a refused request is answered from the
// check state. The frame_limit channel is ready only while no request is in
// progress.
`default_nettype none

module bitmap_frame_allocator #(
	parameter int unsigned MAP_WORD_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire bfa_pkg::req_t         req,
	output logic                       done,
	output bfa_pkg::res_t              result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [bfa_pkg::CNT_W-1:0] cfg_data
);
	import bfa_pkg::*;

	localparam int unsigned W         = MAP_WORD_BITS;
	localparam int unsigned MAP_WORDS = (FRAMES_TOTAL + W - 1) / W;
	localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned DIV_SH    = FRAME_W + $clog2(W);
	localparam int unsigned PROD_W    = 2 * FRAME_W + 2;
	localparam logic [PROD_W-1:0] DIV_MUL =
		PROD_W'(((1 << DIV_SH) + W - 1) / W);

	state_t             state_q, state_d;
	req_t               req_q;
	logic [CNT_W-1:0]   limit_q;
	logic [CNT_W-1:0]   used_q, used_d;
	logic               done_q;
	res_t               result_q;

	logic [FRAME_W-1:0] lo_q;
	logic [CNT_W-1:0]   hi_q;
	logic               set_q;
	logic [FRAME_W-1:0] res_frame_q;
	logic [AW-1:0]      wptr_q;
	logic [CNT_W-1:0]   wbase_q;
	logic [CNT_W-1:0]   run_q;
	logic [MAP_WORDS-1:0] wvalid_q;

	logic               vld_s1;
	logic [AW-1:0]      addr_s1;
	logic [CNT_W-1:0]   base_s1;
	logic               wvalid_s1;

	logic               finish;
	logic [1:0]         fin_status;
	logic [FRAME_W-1:0] fin_frame;
	logic               issue;
	logic               issue_scan;
	logic               issue_mark;
	logic               bad_req;
	logic [CNT_W-1:0]   cnt;
	logic [CNT_W-1:0]   free_now;
	logic [CNT_W:0]     range_end;
	logic [CNT_W-1:0]   used_add;
	logic [CNT_W-1:0]   used_sub;
	logic               cfg_acc;
	logic [CNT_W-1:0]   cfg_limit;
	logic [PROD_W-1:0]  div_prod;
	logic [CNT_W-1:0]   base_prod;

	logic [W-1:0]       ram_rdata;
	logic [W-1:0]       rd_word;
	logic [W-1:0]       rng_mask;
	logic [W-1:0]       wdata;
	logic               we;
	eval_t              ev;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign done      = done_q;
	assign result    = result_q;

	// request decode and count arithmetic
	always_comb begin
		cnt       = req_q.frame_count;
		free_now  = limit_q - used_q;
		range_end = {1'b0, CNT_W'(req_q.start_frame)} + {1'b0, cnt};
		bad_req   = (cnt == '0) || !((req_q.req_type == REQ_ALLOC)
			|| (req_q.req_type == REQ_RELEASE) || (req_q.req_type == REQ_RESERVE));
		used_add  = (cnt > free_now) ? limit_q : (used_q + cnt);
		used_sub  = (cnt > used_q) ? '0 : (used_q - cnt);
		cfg_limit = cfg_data;
		if (cfg_limit == '0) begin
			cfg_limit = CNT_W'(1);
		end
		if (cfg_limit > MAX_FRAMES) begin
			cfg_limit = MAX_FRAMES;
		end
	end

	// word addressing: frame to word index by reciprocal, and index to base
	assign div_prod   = PROD_W'(lo_q) * DIV_MUL;
	assign base_prod  = CNT_W'(wptr_q) * CNT_W'(W);

	assign issue_scan = (state_q == ST_SCAN) && (wbase_q < limit_q);
	assign issue_mark = (state_q == ST_MARK) && (wbase_q < hi_q);
	assign issue      = issue_scan || issue_mark;

	// next state and result control
	always_comb begin
		state_d    = state_q;
		finish     = 1'b0;
		fin_status = STAT_DONE;
		fin_frame  = '0;
		used_d     = used_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (bad_req) begin
					finish     = 1'b1;
					fin_status = STAT_BAD;
					state_d    = ST_IDLE;
				end else if (req_q.req_type == REQ_ALLOC) begin
					if (cnt > free_now) begin
						finish     = 1'b1;
						fin_status = STAT_NO_RUN;
						state_d    = ST_IDLE;
					end else begin
						state_d = ST_SCAN;
					end
				end else if (range_end > {1'b0, limit_q}) begin
					finish     = 1'b1;
					fin_status = STAT_BAD;
					state_d    = ST_IDLE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_SCAN: begin
				if (vld_s1 && ev.found) begin
					state_d = ST_DIV;
				end else if (!vld_s1 && !issue_scan) begin
					finish     = 1'b1;
					fin_status = STAT_NO_RUN;
					state_d    = ST_IDLE;
				end
			end
			ST_DIV: begin
				state_d = ST_BASE;
			end
			ST_BASE: begin
				state_d = ST_MARK;
			end
			ST_MARK: begin
				if (!issue_mark && !vld_s1) begin
					finish     = 1'b1;
					fin_status = STAT_DONE;
					fin_frame  = res_frame_q;
					used_d     = set_q ? used_add : used_sub;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// map word read back: unwritten words hold all frames used
	assign rd_word = wvalid_s1 ? ram_rdata : '1;

	// set or clear the range bits of the returning word; frame zero stays used
	always_comb begin
		for (int j = 0; j < W; j++) begin
			rng_mask[j] = ((CNT_W+1)'(base_s1) + (CNT_W+1)'(j) >= (CNT_W+1)'(lo_q))
				&& ((CNT_W+1)'(base_s1) + (CNT_W+1)'(j) < (CNT_W+1)'(hi_q));
		end
		wdata = set_q ? (rd_word | rng_mask) : (rd_word & ~rng_mask);
		if (addr_s1 == '0) begin
			wdata[0] = 1'b1;
		end
	end

	assign we = (state_q == ST_MARK) && vld_s1;

	bfa_ram #(
		.WIDTH (W),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (wdata),
		.re    (issue),
		.raddr (wptr_q),
		.rdata (ram_rdata)
	);

	bfa_word_eval #(
		.MAP_WORD_BITS (W)
	) u_eval (
		.used_word (rd_word),
		.base      (base_s1),
		.limit     (limit_q),
		.run_in    (run_q),
		.count     (cnt),
		.res       (ev)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			limit_q  <= MAX_FRAMES;
			used_q   <= MAX_FRAMES;
			done_q   <= 1'b0;
			vld_s1   <= 1'b0;
			wvalid_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			vld_s1  <= issue;
			if (cfg_acc) begin
				limit_q <= cfg_limit;
				used_q  <= cfg_limit;
			end else begin
				used_q <= used_d;
			end
			if (we) begin
				wvalid_q[addr_s1] <= 1'b1;
			end
		end
	end

	// request, range and pipeline payload
	always_ff @(posedge clk) begin
		if (start && (state_q == ST_IDLE)) begin
			req_q <= req;
		end
		case (state_q)
			ST_CHECK: begin
				wptr_q      <= '0;
				wbase_q     <= '0;
				run_q       <= '0;
				lo_q        <= req_q.start_frame;
				hi_q        <= range_end[CNT_W-1:0];
				set_q       <= (req_q.req_type == REQ_RESERVE);
				res_frame_q <= '0;
			end
			ST_SCAN: begin
				if (vld_s1) begin
					if (ev.found) begin
						lo_q        <= ev.first;
						hi_q        <= CNT_W'(ev.first) + cnt;
						set_q       <= 1'b1;
						res_frame_q <= ev.first;
					end else begin
						run_q <= ev.run_next;
					end
				end
			end
			ST_DIV: begin
				wptr_q <= div_prod[DIV_SH +: AW];
			end
			ST_BASE: begin
				wbase_q <= base_prod;
			end
			default: begin
			end
		endcase
		// advance the word pointer on every map read
		if (issue) begin
			wptr_q    <= wptr_q + AW'(1);
			wbase_q   <= wbase_q + CNT_W'(W);
			addr_s1   <= wptr_q;
			base_s1   <= wbase_q;
			wvalid_s1 <= wvalid_q[wptr_q];
		end
		if (finish) begin
			result_q.status     <= fin_status;
			result_q.frame      <= fin_frame;
			result_q.free_count <= limit_q - used_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/bfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module bfa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/bfa_word_eval.sv
// First-fit run search over one map word, continuing a run from lower words.
`default_nettype none

module bfa_word_eval #(
	parameter int unsigned MAP_WORD_BITS = 64
) (
	input  wire logic [MAP_WORD_BITS-1:0]  used_word,
	input  wire logic [bfa_pkg::CNT_W-1:0] base,
	input  wire logic [bfa_pkg::CNT_W-1:0] limit,
	input  wire logic [bfa_pkg::CNT_W-1:0] run_in,
	input  wire logic [bfa_pkg::CNT_W-1:0] count,
	output bfa_pkg::eval_t                 res
);
	import bfa_pkg::*;

	localparam int unsigned W  = MAP_WORD_BITS;
	localparam int unsigned CB = $clog2(W + 1);
	localparam int unsigned JW = $clog2(W);

	logic [CNT_W:0]          lim_rem;
	logic [W-1:0]            free;
	logic [W-1:0]            pf;
	logic [W-1:0]            lvl [CB];
	logic [W-1:0]            acc;
	logic [W-1:0]            win;
	logic [W-1:0]            span;
	logic [W-1:0]            hit;
	logic [CB-1:0]           low_cnt;
	logic signed [CNT_W+1:0] need;
	logic [JW-1:0]           hit_idx;
	logic [JW-1:0]           top_used;
	logic                    any_used;
	logic [CNT_W+1:0]        first_w;

	always_comb begin
		// free bits: clear in the map, below the limit, never frame zero
		lim_rem = {1'b0, limit} - {1'b0, base};
		for (int j = 0; j < W; j++) begin
			free[j] = ~used_word[j] && ((CNT_W+1)'(j) < lim_rem);
		end
		if (base == '0) begin
			free[0] = 1'b0;
		end

		// all bits from the bottom up to each position are free
		pf[0] = free[0];
		for (int j = 1; j < W; j++) begin
			pf[j] = pf[j-1] & free[j];
		end

		// windows of power-of-two length that end at each position
		lvl[0] = free;
		for (int k = 1; k < CB; k++) begin
			lvl[k] = lvl[k-1] & (lvl[k-1] << (1 << (k - 1)));
		end

		// compose a window of exactly count bits wholly inside the word
		acc = '1;
		for (int k = 0; k < CB; k++) begin
			low_cnt = count[CB-1:0] & CB'((1 << k) - 1);
			if (count[k]) begin
				acc = acc & (lvl[k] << low_cnt);
			end
		end
		win = (count > CNT_W'(W)) ? '0 : acc;

		// runs that reach down into lower words
		need = $signed({2'b00, count}) - $signed({2'b00, run_in}) - (CNT_W+2)'(1);
		for (int j = 0; j < W; j++) begin
			span[j] = pf[j] && ($signed((CNT_W+2)'(j)) >= need);
		end

		hit = win | span;

		// lowest hit position
		hit_idx = '0;
		for (int j = W - 1; j >= 0; j--) begin
			if (hit[j]) begin
				hit_idx = JW'(j);
			end
		end

		// highest used position, for the run carried upward
		any_used = ~&free;
		top_used = '0;
		for (int j = 0; j < W; j++) begin
			if (!free[j]) begin
				top_used = JW'(j);
			end
		end

		first_w = (CNT_W+2)'(base) + (CNT_W+2)'(hit_idx) + (CNT_W+2)'(1)
			- (CNT_W+2)'(count);

		res.found    = |hit;
		res.first    = first_w[FRAME_W-1:0];
		res.run_next = any_used ? (CNT_W'(W - 1) - CNT_W'(top_used))
			: (run_in + CNT_W'(W));
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb_bitmap_frame_allocator.sv
// Self-checking testbench of the bitmap frame allocator: directed rows, then random phases.
module tb_bitmap_frame_allocator;
	import bfa_pkg::*;

	// code that the block must refuse
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int unsigned PHASES = 10;
	localparam int unsigned PHASE_ITEMS = 192;
	localparam int unsigned DRAIN_CYCLES = 150;
	localparam int unsigned PRINT_CAP = 60;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	res_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	// shadow state of the allocator
	bit frame_used [FRAMES_TOTAL];
	int unsigned frames_in_use;
	int unsigned frame_lim;

	res_t pending_results [$];
	int unsigned mismatch_count;
	bit burst_mode;

	typedef struct {
		req_t r;
		bit   typed;
		res_t want;
	} row_t;

	row_t directed_rows [$];

	bitmap_frame_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#12_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic note_mismatch(input string what, input int got, input int want);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// shadow of a frame_limit register write
	function automatic void apply_limit(input logic [CNT_W-1:0] v);
		int unsigned lim;
		lim = v;
		if (lim == 0)
			lim = 1;
		if (lim > FRAMES_TOTAL)
			lim = FRAMES_TOTAL;
		frame_lim = lim;
		frames_in_use = lim;
	endfunction

	function automatic void count_up(input int unsigned n);
		if (n > frame_lim - frames_in_use)
			frames_in_use = frame_lim;
		else
			frames_in_use += n;
	endfunction

	// apply one request to the shadow state and return the result it gives
	function automatic res_t serve_request(input req_t r);
		res_t o;
		int unsigned cnt, first_free, run, i;
		bit found;
		cnt = r.frame_count;
		o.status = STAT_DONE;
		o.frame = '0;
		if (cnt == 0 || r.req_type == REQ_UNKNOWN) begin
			o.status = STAT_BAD;
		end else if (r.req_type == REQ_ALLOC) begin
			if (cnt > frame_lim - frames_in_use) begin
				o.status = STAT_NO_RUN;
			end else begin
				// first fit over frames 1 .. limit-1
				run = 0;
				first_free = 0;
				found = 1'b0;
				i = 1;
				while (i < frame_lim && !found) begin
					if (frame_used[i]) begin
						run = 0;
					end else begin
						if (run == 0)
							first_free = i;
						run++;
						found = (run == cnt);
					end
					i++;
				end
				if (!found) begin
					o.status = STAT_NO_RUN;
				end else begin
					for (i = 0; i < cnt; i++)
						frame_used[first_free + i] = 1'b1;
					count_up(cnt);
					o.frame = FRAME_W'(first_free);
				end
			end
		end else if (int'(r.start_frame) + cnt > frame_lim) begin
			o.status = STAT_BAD;
		end else if (r.req_type == REQ_RELEASE) begin
			for (i = 0; i < cnt; i++)
				frame_used[r.start_frame + i] = 1'b0;
			// frame 0 never leaves the used set
			frame_used[0] = 1'b1;
			frames_in_use = (cnt > frames_in_use) ? 0 : frames_in_use - cnt;
		end else begin
			for (i = 0; i < cnt; i++)
				frame_used[r.start_frame + i] = 1'b1;
			count_up(cnt);
		end
		o.free_count = CNT_W'(frame_lim - frames_in_use);
		return o;
	endfunction

	function automatic req_t mk_req(input logic [1:0] t, input int unsigned s,
			input int unsigned c);
		req_t r;
		r.req_type = t;
		r.start_frame = FRAME_W'(s);
		r.frame_count = CNT_W'(c);
		return r;
	endfunction

	task automatic add_row(input logic [1:0] t, input int unsigned s, input int unsigned c,
			input bit typed, input logic [1:0] st, input int unsigned fr,
			input int unsigned fc);
		row_t row;
		row.r = mk_req(t, s, c);
		row.typed = typed;
		row.want.status = st;
		row.want.frame = FRAME_W'(fr);
		row.want.free_count = CNT_W'(fc);
		directed_rows.push_back(row);
	endtask

	// drive one transaction from a falling edge; return at the falling edge after it
	task automatic issue(input req_t r, input bit typed, input res_t want);
		int unsigned gap;
		res_t got;
		gap = burst_mode ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		got = serve_request(r);
		pending_results.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	// write frame_limit once every outstanding result is back
	task automatic write_limit(input logic [CNT_W-1:0] v);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		apply_limit(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// length of a release or reserve range starting at s, mostly short, always in range
	function automatic int unsigned range_len(input int unsigned s);
		int unsigned room;
		room = frame_lim - s;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(1, room);
		return $urandom_range(1, (room < 16) ? room : 16);
	endfunction

	function automatic req_t pick_request();
		int unsigned pick, s;
		pick = $urandom_range(0, 99);
		s = $urandom_range(0, frame_lim - 1);
		if (pick < 45) begin
			pick = $urandom_range(0, 19);
			if (pick < 16)
				return mk_req(REQ_ALLOC, $urandom_range(0, 4095), $urandom_range(1, 8));
			if (pick < 19)
				return mk_req(REQ_ALLOC, $urandom_range(0, 4095), $urandom_range(1, frame_lim));
			return mk_req(REQ_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 8191));
		end
		if (pick < 72)
			return mk_req(REQ_RELEASE, s, range_len(s));
		if (pick < 88)
			return mk_req(REQ_RESERVE, s, range_len(s));
		// noise: any field value, refused codes included
		return mk_req(2'($urandom_range(0, 3)), $urandom_range(0, 4095),
			$urandom_range(0, 8191));
	endfunction

	// check each result against the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result with nothing outstanding, status", result.status, -1);
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					note_mismatch("status", result.status, want.status);
				if (result.frame !== want.frame)
					note_mismatch("frame", result.frame, want.frame);
				if (result.free_count !== want.free_count)
					note_mismatch("free_count", result.free_count, want.free_count);
			end
		end
	end

	initial begin
		res_t none;
		logic [CNT_W-1:0] limits [PHASES];
		none = '0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatch_count = 0;
		burst_mode = 1'b0;
		for (int i = 0; i < FRAMES_TOTAL; i++)
			frame_used[i] = 1'b1;
		frame_lim = FRAMES_TOTAL;
		frames_in_use = FRAMES_TOTAL;

		// out of reset: every frame used, nothing free
		add_row(REQ_ALLOC,   0,    1,    1, STAT_NO_RUN, 0, 0);
		add_row(REQ_ALLOC,   0,    0,    1, STAT_BAD,    0, 0);
		add_row(REQ_UNKNOWN, 0,    5,    1, STAT_BAD,    0, 0);
		add_row(REQ_RELEASE, 4095, 2,    1, STAT_BAD,    0, 0);
		add_row(REQ_RESERVE, 4095, 8191, 1, STAT_BAD,    0, 0);
		// free the whole map; frame 0 stays used
		add_row(REQ_RELEASE, 0,    4096, 1, STAT_DONE,   0, 4096);
		add_row(REQ_ALLOC,   0,    4096, 1, STAT_NO_RUN, 0, 4096);
		add_row(REQ_ALLOC,   0,    8191, 1, STAT_NO_RUN, 0, 4096);
		add_row(REQ_ALLOC,   0,    4095, 1, STAT_DONE,   1, 1);
		add_row(REQ_RELEASE, 4095, 1,    1, STAT_DONE,   0, 2);
		add_row(REQ_ALLOC,   0,    2,    0, STAT_DONE,   0, 0);
		add_row(REQ_ALLOC,   0,    1,    0, STAT_DONE,   0, 0);
		// reserve over used frames saturates the count
		add_row(REQ_RESERVE, 100,  50,   0, STAT_DONE,   0, 0);
		add_row(REQ_RELEASE, 0,    64,   0, STAT_DONE,   0, 0);
		add_row(REQ_ALLOC,   4095, 63,   0, STAT_DONE,   0, 0);
		add_row(REQ_RELEASE, 1,    4095, 0, STAT_DONE,   0, 0);
		// release with nothing counted as used floors at zero
		add_row(REQ_RELEASE, 2048, 2048, 0, STAT_DONE,   0, 0);
		add_row(REQ_RESERVE, 0,    4096, 0, STAT_DONE,   0, 0);
		add_row(REQ_RELEASE, 4000, 96,   0, STAT_DONE,   0, 0);
		add_row(REQ_ALLOC,   0,    96,   0, STAT_DONE,   0, 0);
		add_row(REQ_RELEASE, 1,    1,    0, STAT_DONE,   0, 0);
		add_row(REQ_ALLOC,   0,    1,    0, STAT_DONE,   0, 0);
		// count says one free, but only frame 0 was released
		add_row(REQ_RELEASE, 0,    1,    0, STAT_DONE,   0, 0);
		add_row(REQ_ALLOC,   0,    1,    0, STAT_DONE,   0, 0);
		add_row(REQ_UNKNOWN, 4095, 8191, 0, STAT_DONE,   0, 0);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].want);

		// limit settings per phase: zero and oversize codes, extremes, random
		limits[0] = 0;
		limits[1] = 8191;
		limits[2] = 1;
		limits[3] = 4096;
		limits[4] = 64;
		limits[5] = 4097;
		limits[6] = 200;
		limits[7] = CNT_W'($urandom_range(2, 4096));
		limits[8] = CNT_W'($urandom_range(2, 1024));
		limits[9] = 4095;

		for (int p = 0; p < PHASES; p++) begin
			write_limit(limits[p]);
			burst_mode = (p % 3 == 2);
			// open each phase by freeing the managed range
			issue(mk_req(REQ_RELEASE, 0, frame_lim), 1'b0, none);
			for (int n = 1; n < PHASE_ITEMS; n++)
				issue(pick_request(), 1'b0, none);
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
